>>> hw/rtl/hpbe_pkg.sv
// Shared types, constants and helpers for the piecewise basis evaluation unit.
// No dependencies; imported by hpbe_div_pipe and hierarchical_pw_basis_eval_unit.
package hpbe_pkg;

    // Quotient bits produced by one pass through the divider pipeline.
    localparam int DIV_STEPS = 31;

    localparam logic [1:0] KIND_LINEAR    = 2'd0;
    localparam logic [1:0] KIND_QUADRATIC = 2'd1;
    localparam logic [1:0] KIND_CUBIC     = 2'd2;

    // type-1 value source
    localparam logic [1:0] V1_ZERO  = 2'd0;
    localparam logic [1:0] V1_ONE   = 2'd1;
    localparam logic [1:0] V1_LIN   = 2'd2;
    localparam logic [1:0] V1_CUBIC = 2'd3;

    // type-2 gradient source
    localparam logic [1:0] G2_ZERO = 2'd0;
    localparam logic [1:0] G2_ONE  = 2'd1;
    localparam logic [1:0] G2_POLY = 2'd2;

    localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
    localparam logic [31:0]        THREE_Q30 = 32'hC000_0000;
    localparam logic signed [31:0] ONE_Q20   = 32'sh0010_0000;
    localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

    // Sideband that travels with an item through the divider pipelines.
    typedef struct packed {
        logic               cubic;
        logic               left;
        logic               t_zero;
        logic               t_full;
        logic [1:0]         v1_sel;
        logic               g1_en;
        logic               g1_neg;
        logic               g1_ovf;
        logic               v2_en;
        logic [1:0]         g2_sel;
        logic [31:0]        den;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] g2;
    } side_t;

    typedef struct packed {
        logic signed [31:0] value_one;
        logic signed [31:0] slope_one;
        logic signed [31:0] value_two;
        logic signed [31:0] slope_two;
    } res_t;

    // Q30 to Q20, round half up (floor of (v + 512) / 1024).
    function automatic logic signed [31:0] q30_to_q20(input logic signed [33:0] v);
        logic signed [33:0] w;
        w = v + 34'sd512;
        w = w >>> 10;
        return w[31:0];
    endfunction

endpackage

>>> hw/rtl/hpbe_div_pipe.sv
// Restoring unsigned divider, one quotient bit per register stage.
// Depends on hpbe_pkg (DIV_STEPS, side_t). Divisor travels in the sideband.
module hpbe_div_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [31:0]                         in_rem,
    input  logic [hpbe_pkg::DIV_STEPS-1:0]      in_low,
    input  hpbe_pkg::side_t                     in_side,
    output logic                                out_valid,
    output logic [hpbe_pkg::DIV_STEPS-1:0]      out_quo,
    output hpbe_pkg::side_t                     out_side
);
    import hpbe_pkg::*;

    logic                 valid_reg [DIV_STEPS];
    logic [31:0]          rem_reg   [DIV_STEPS];
    logic [31:0]          rem_next  [DIV_STEPS];
    logic [DIV_STEPS-1:0] low_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0] low_next  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_next  [DIV_STEPS];
    side_t                side_reg  [DIV_STEPS];

    logic                 src_valid [DIV_STEPS];
    logic [31:0]          src_rem   [DIV_STEPS];
    logic [DIV_STEPS-1:0] src_low   [DIV_STEPS];
    logic [DIV_STEPS-1:0] src_quo   [DIV_STEPS];
    side_t                src_side  [DIV_STEPS];

    always_comb
    begin
        src_valid[0] = in_valid;
        src_rem[0]   = in_rem;
        src_low[0]   = in_low;
        src_quo[0]   = '0;
        src_side[0]  = in_side;
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            src_valid[i] = valid_reg[i-1];
            src_rem[i]   = rem_reg[i-1];
            src_low[i]   = low_reg[i-1];
            src_quo[i]   = quo_reg[i-1];
            src_side[i]  = side_reg[i-1];
        end
    end

    // one compare-subtract per stage; remainder stays below the divisor
    always_comb
    begin
        logic [32:0] shifted;
        logic [33:0] diff;
        shifted = '0;
        diff    = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            shifted = {src_rem[i], src_low[i][DIV_STEPS-1]};
            diff    = {1'b0, shifted} - {2'b00, src_side[i].den};
            if (!diff[33])
            begin
                rem_next[i] = diff[31:0];
            end
            else
            begin
                rem_next[i] = shifted[31:0];
            end
            low_next[i] = {src_low[i][DIV_STEPS-2:0], 1'b0};
            quo_next[i] = {src_quo[i][DIV_STEPS-2:0], ~diff[33]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                valid_reg[i] <= src_valid[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= low_next[i];
                quo_reg[i]  <= quo_next[i];
                side_reg[i] <= src_side[i];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_quo   = quo_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

>>> hw/rtl/hierarchical_pw_basis_eval_unit.sv
// Piecewise linear / cubic Hermite hierarchical basis evaluation, top level.
// Depends on hpbe_pkg and hpbe_div_pipe (two instances).
//
// Usage:
//   Point channel (point_valid / point_stall) carries one item: eval_point,
//   node_point, left_point, right_point (signed Q2.30) and is_root.
//   Result channel (result_valid / result_stall) returns one item per point:
//   value_one, slope_one, value_two, slope_two (signed Q12.20).
//   kind_write_en / kind_write_data set the basis kind (0 linear, 1 treated as
//   linear, 2 cubic Hermite); write it only while the unit is idle.
// Throughput: one item per cycle while point_stall is low.
// Pipeline: the input register loads at the accepting edge; it is followed
//   by two 31-stage restoring dividers (local coordinate, then gradient
//   divided by the interval) plus seven more register stages: setup,
//   coordinate fixup, two multiplier stages, scaling multiply, rounding,
//   output register.
// Stall: the whole pipeline shares one advance enable. An output register
//   plus a one-item skid register sit at the end, so a stalled receiver does
//   not stop intake at once; point_stall rises only once the skid holds an
//   item, and it is a registered signal.
// Reset: asynchronous, active low; clears all valid bits, the skid and the
//   basis kind (linear). No clearing pass, the unit is ready right away.
module hierarchical_pw_basis_eval_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               kind_write_en,
    input  logic [1:0]         kind_write_data,
    input  logic               point_valid,
    output logic               point_stall,
    input  logic signed [31:0] eval_point,
    input  logic signed [31:0] node_point,
    input  logic signed [31:0] left_point,
    input  logic signed [31:0] right_point,
    input  logic               is_root,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] value_one,
    output logic signed [31:0] slope_one,
    output logic signed [31:0] value_two,
    output logic signed [31:0] slope_two
);
    import hpbe_pkg::*;

    localparam logic signed [31:0] V2_LIMIT = 32'sh0040_0000;

    logic [1:0] kind_reg;
    logic       en;

    // stage 0: input capture
    logic               s0_valid_reg;
    logic signed [31:0] x_reg, n_reg, l_reg, r_reg;
    logic               root_reg;

    // stage 1: setup
    logic               s1_valid_reg;
    logic [31:0]        s1_rem_reg, s1_rem_next;
    side_t              s1_side_reg, s1_side_next;

    // coordinate divider
    logic                 div1_valid;
    logic [DIV_STEPS-1:0] div1_quo;
    side_t                div1_side;

    // stage 2: local coordinate
    logic        s2_valid_reg;
    logic [30:0] s2_t_reg, s2_t_next, s2_u_reg, s2_u_next;
    side_t       s2_side_reg;

    // stage 3: squares and cross product
    logic        s3_valid_reg;
    logic [30:0] s3_tt_reg, s3_uu_reg, s3_tu_reg, s3_t_reg, s3_u_reg;
    logic [61:0] tt_full, uu_full, tu_full;
    side_t       s3_side_reg;

    // stage 4: cubic shapes
    logic               s4_valid_reg;
    logic [30:0]        s4_p1_reg, s4_p1_next, s4_p2_reg, s4_p2_next;
    logic [30:0]        s4_mag_reg, s4_mag_next, s4_t_reg;
    logic signed [33:0] s4_g2raw_reg, s4_g2raw_next;
    side_t              s4_side_reg;

    // stage 5: scaling multiply, Q20 rounding, gradient dividend
    logic        s5_valid_reg;
    logic [62:0] s5_vprod_reg, s5_vprod_next;
    logic [51:0] s5_gnum_reg, s5_gnum_next;
    side_t       s5_side_reg, s5_side_next;

    // stage 6: type-2 value rounding, gradient overflow check
    logic        s6_valid_reg;
    logic [31:0] s6_rem_reg;
    logic [30:0] s6_low_reg;
    side_t       s6_side_reg, s6_side_next;

    // gradient divider
    logic                 div2_valid;
    logic [DIV_STEPS-1:0] div2_quo;
    side_t                div2_side;

    // output register and skid
    logic out_valid_reg, skid_valid_reg;
    res_t out_res_reg, skid_res_reg, res_next;
    logic pop, push;

    //------------------------------------------------------------------
    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_LINEAR;
        end
        else if (kind_write_en)
        begin
            kind_reg <= kind_write_data;
        end
    end

    assign en          = ~skid_valid_reg;
    assign point_stall = skid_valid_reg;

    //------------------------------------------------------------------
    // stage 1: interval differences, branch decisions, divider operands
    always_comb
    begin
        logic signed [32:0] xs, ns, ls, rs;
        logic signed [32:0] d_left, d_right, num_xl, num_xn, num_rx, num, den;
        logic lt_n, eq_n, gt_n, ge_l, gt_l, le_r, lt_r, eq_r, r_eq_n, cubic;
        xs = {x_reg[31], x_reg};
        ns = {n_reg[31], n_reg};
        ls = {l_reg[31], l_reg};
        rs = {r_reg[31], r_reg};
        d_left  = ns - ls;
        d_right = rs - ns;
        num_xl  = xs - ls;
        num_xn  = xs - ns;
        num_rx  = rs - xs;
        lt_n   = x_reg < n_reg;
        eq_n   = x_reg == n_reg;
        gt_n   = ~lt_n & ~eq_n;
        ge_l   = x_reg >= l_reg;
        gt_l   = x_reg > l_reg;
        le_r   = x_reg <= r_reg;
        lt_r   = x_reg < r_reg;
        eq_r   = x_reg == r_reg;
        r_eq_n = r_reg == n_reg;
        cubic  = kind_reg == KIND_CUBIC;

        // linear right half measures from the right end, cubic from the node
        num = lt_n ? num_xl : (cubic ? num_xn : num_rx);
        den = lt_n ? d_left : d_right;

        s1_side_next        = '0;
        s1_side_next.cubic  = cubic;
        s1_side_next.left   = lt_n;
        s1_side_next.t_zero = (num <= 33'sd0) | (den <= 33'sd0);
        s1_side_next.t_full = num >= den;
        s1_side_next.den    = den[31:0];
        s1_side_next.v1_sel = V1_ZERO;
        s1_side_next.g2_sel = G2_ZERO;

        if (root_reg)
        begin
            if (ge_l & le_r)
            begin
                s1_side_next.v1_sel = V1_ONE;
            end
        end
        else if (!cubic)
        begin
            if (lt_n & ge_l)
            begin
                s1_side_next.v1_sel = V1_LIN;
            end
            else if (~lt_n & le_r)
            begin
                s1_side_next.v1_sel = r_eq_n ? V1_ONE : V1_LIN;
            end
            s1_side_next.g1_en  = (lt_n & gt_l) | (gt_n & lt_r);
            s1_side_next.g1_neg = gt_n;
        end
        else
        begin
            if ((lt_n & ge_l) | (~lt_n & lt_r))
            begin
                s1_side_next.v1_sel = V1_CUBIC;
            end
            else if (eq_n & eq_r)
            begin
                s1_side_next.v1_sel = V1_ONE;
            end
            s1_side_next.g1_en  = (lt_n & gt_l) | (gt_n & lt_r);
            s1_side_next.g1_neg = gt_n;
            s1_side_next.v2_en  = (~gt_n & gt_l) | (~lt_n & lt_r);
            if ((lt_n & gt_l) | (gt_n & lt_r))
            begin
                s1_side_next.g2_sel = G2_POLY;
            end
            else if (eq_n)
            begin
                s1_side_next.g2_sel = G2_ONE;
            end
        end
        s1_rem_next = num[31:0];
    end

    //------------------------------------------------------------------
    // t = floor(num * 2^31 / den) >> 1; the divider yields 31 quotient bits
    hpbe_div_pipe u_coord_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_rem    (s1_rem_reg),
        .in_low    ('0),
        .in_side   (s1_side_reg),
        .out_valid (div1_valid),
        .out_quo   (div1_quo),
        .out_side  (div1_side)
    );

    // stage 2
    always_comb
    begin
        if (div1_side.t_zero)
        begin
            s2_t_next = '0;
        end
        else if (div1_side.t_full)
        begin
            s2_t_next = ONE_Q30;
        end
        else
        begin
            s2_t_next = {1'b0, div1_quo[DIV_STEPS-1:1]};
        end
        s2_u_next = ONE_Q30 - s2_t_next;
    end

    // stage 3
    assign tt_full = s2_t_reg * s2_t_reg;
    assign uu_full = s2_u_reg * s2_u_reg;
    assign tu_full = s2_t_reg * s2_u_reg;

    // stage 4: v1 shape tt(3-2t) or uu(1+2t), v2 shape tt*u or uu*t
    always_comb
    begin
        logic [30:0] a, b2;
        logic [31:0] b1, tt3;
        logic [62:0] p1_full, p2_full;
        logic [32:0] tu6;
        logic signed [33:0] tt3_s, t_s;
        a  = s3_side_reg.left ? s3_tt_reg : s3_uu_reg;
        b1 = s3_side_reg.left ? (THREE_Q30 - {s3_t_reg, 1'b0})
                              : ({1'b0, ONE_Q30} + {s3_t_reg, 1'b0});
        b2 = s3_side_reg.left ? s3_u_reg : s3_t_reg;
        p1_full = a * b1;
        p2_full = a * b2;
        s4_p1_next = p1_full[60:30];
        s4_p2_next = p2_full[60:30];

        tu6 = ({2'b00, s3_tu_reg} << 2) + ({2'b00, s3_tu_reg} << 1);
        s4_mag_next = s3_side_reg.cubic ? tu6[30:0] : ONE_Q30;

        tt3   = ({1'b0, s3_tt_reg} << 1) + {1'b0, s3_tt_reg};
        tt3_s = $signed({2'b00, tt3});
        t_s   = $signed({3'b000, s3_t_reg});
        if (s3_side_reg.left)
        begin
            s4_g2raw_next = tt3_s - (t_s <<< 1);
        end
        else
        begin
            s4_g2raw_next = tt3_s - (t_s <<< 2) + $signed({3'b000, ONE_Q30});
        end
    end

    // stage 5
    always_comb
    begin
        s5_vprod_next = s4_side_reg.den * s4_p2_reg;
        s5_gnum_next  = {1'b0, s4_mag_reg, 20'b0} + {21'b0, s4_side_reg.den[31:1]};
        s5_side_next  = s4_side_reg;
        case (s4_side_reg.v1_sel)
            V1_ONE:   s5_side_next.v1 = ONE_Q20;
            V1_LIN:   s5_side_next.v1 = q30_to_q20($signed({3'b000, s4_t_reg}));
            V1_CUBIC: s5_side_next.v1 = q30_to_q20($signed({3'b000, s4_p1_reg}));
            default:  s5_side_next.v1 = '0;
        endcase
        case (s4_side_reg.g2_sel)
            G2_ONE:  s5_side_next.g2 = ONE_Q20;
            G2_POLY: s5_side_next.g2 = q30_to_q20(s4_g2raw_reg);
            default: s5_side_next.g2 = '0;
        endcase
    end

    // stage 6: round(d * p / 2^40), sign by half; quotient overflow test
    always_comb
    begin
        logic [63:0]        vsum;
        logic signed [31:0] vq;
        vsum = {1'b0, s5_vprod_reg} + (64'd1 << 39);
        vq   = $signed({8'b0, vsum[63:40]});
        s6_side_next = s5_side_reg;
        if (!s5_side_reg.v2_en)
        begin
            s6_side_next.v2 = '0;
        end
        else if (s5_side_reg.left)
        begin
            s6_side_next.v2 = -vq;
        end
        else
        begin
            s6_side_next.v2 = vq;
        end
        s6_side_next.g1_ovf = {11'b0, s5_gnum_reg[51:31]} >= s5_side_reg.den;
    end

    //------------------------------------------------------------------
    // gradient = round(mag * 2^20 / d)
    hpbe_div_pipe u_grad_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .in_rem    (s6_rem_reg),
        .in_low    (s6_low_reg),
        .in_side   (s6_side_reg),
        .out_valid (div2_valid),
        .out_quo   (div2_quo),
        .out_side  (div2_side)
    );

    always_comb
    begin
        logic signed [31:0] q;
        q = $signed({1'b0, div2_quo});
        res_next.value_one = div2_side.v1;
        res_next.value_two = div2_side.v2;
        res_next.slope_two = div2_side.g2;
        if (!div2_side.g1_en)
        begin
            res_next.slope_one = '0;
        end
        else if (div2_side.g1_ovf)
        begin
            res_next.slope_one = div2_side.g1_neg ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            res_next.slope_one = div2_side.g1_neg ? -q : q;
        end
    end

    //------------------------------------------------------------------
    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= point_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= div1_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg        <= eval_point;
            n_reg        <= node_point;
            l_reg        <= left_point;
            r_reg        <= right_point;
            root_reg     <= is_root;
            s1_rem_reg   <= s1_rem_next;
            s1_side_reg  <= s1_side_next;
            s2_t_reg     <= s2_t_next;
            s2_u_reg     <= s2_u_next;
            s2_side_reg  <= div1_side;
            s3_tt_reg    <= tt_full[60:30];
            s3_uu_reg    <= uu_full[60:30];
            s3_tu_reg    <= tu_full[60:30];
            s3_t_reg     <= s2_t_reg;
            s3_u_reg     <= s2_u_reg;
            s3_side_reg  <= s2_side_reg;
            s4_p1_reg    <= s4_p1_next;
            s4_p2_reg    <= s4_p2_next;
            s4_mag_reg   <= s4_mag_next;
            s4_t_reg     <= s3_t_reg;
            s4_g2raw_reg <= s4_g2raw_next;
            s4_side_reg  <= s3_side_reg;
            s5_vprod_reg <= s5_vprod_next;
            s5_gnum_reg  <= s5_gnum_next;
            s5_side_reg  <= s5_side_next;
            s6_rem_reg   <= {11'b0, s5_gnum_reg[51:31]};
            s6_low_reg   <= s5_gnum_reg[30:0];
            s6_side_reg  <= s6_side_next;
        end
    end

    //------------------------------------------------------------------
    // output register with one-item skid
    assign pop  = out_valid_reg & ~result_stall;
    assign push = en & div2_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_res_reg <= res_next;
            end
            else
            begin
                skid_res_reg <= res_next;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign value_one    = out_res_reg.value_one;
    assign slope_one    = out_res_reg.slope_one;
    assign value_two    = out_res_reg.value_two;
    assign slope_two    = out_res_reg.slope_two;

    //------------------------------------------------------------------
    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (value_one >= 32'sd0 && value_one <= ONE_Q20))
        else $error("type-1 value outside [0, 1.0]");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (value_two <= V2_LIMIT && value_two >= -V2_LIMIT))
        else $error("type-2 value beyond interval bound");

endmodule

>>> test/hierarchical_pw_basis_eval_unit_tb.sv
// Self-checking testbench for hierarchical_pw_basis_eval_unit: linear and cubic
// Hermite basis values and gradients predicted in fixed point, checked per item.
// Depends on hpbe_pkg (basis kind codes, result struct) and the RTL top level.
module hierarchical_pw_basis_eval_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hpbe_pkg::*;

    localparam int      PIPE_DEPTH  = 69;
    localparam int      CYCLE_LIMIT = 600000;
    localparam longint  ONE30       = 64'sd1 << 30;
    localparam longint  ONE20       = 64'sd1 << 20;
    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused code, behaves as linear

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               kind_write_en = 1'b0;
    logic [1:0]         kind_write_data = '0;
    logic               point_valid = 1'b0;
    logic               point_stall;
    logic signed [31:0] eval_point = '0;
    logic signed [31:0] node_point = '0;
    logic signed [31:0] left_point = '0;
    logic signed [31:0] right_point = '0;
    logic               is_root = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] value_one;
    logic signed [31:0] slope_one;
    logic signed [31:0] value_two;
    logic signed [31:0] slope_two;

    hierarchical_pw_basis_eval_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .kind_write_en  (kind_write_en),
        .kind_write_data(kind_write_data),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .eval_point     (eval_point),
        .node_point     (node_point),
        .left_point     (left_point),
        .right_point    (right_point),
        .is_root        (is_root),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .value_one      (value_one),
        .slope_one      (slope_one),
        .value_two      (value_two),
        .slope_two      (slope_two)
    );

    always #5 clk = ~clk;

    // Shadow of the basis kind register and the queue of pending basis results.
    logic [1:0] kind_shadow = KIND_LINEAR;
    res_t       basis_q[$];
    int         error_count = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         cycle_count = 0;

    // Idle rates in percent; the hold-off flag pins result_stall high.
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_off = 1'b0;

    // ---------------------------------------------------------------
    // Fixed-point helpers on 64-bit integer values
    // ---------------------------------------------------------------
    // floor(num * 2^30 / den), num clamped to den
    function automatic longint coord30(longint num, longint den);
        bit [63:0] q;
        if (den <= 0 || num <= 0)
            return 0;
        if (num > den)
            num = den;
        q = (64'(num) << 30) / 64'(den);
        return longint'(q);
    endfunction

    // Q30 product, truncated (operands taken as unsigned 64-bit)
    function automatic longint prod30(longint a, longint b);
        bit [63:0] p;
        p = a * b;
        return longint'(p >> 30);
    endfunction

    // Q30 to Q20, round half up == floor((v + 512) / 1024)
    function automatic longint round20(longint v);
        return (v + 512) >>> 10;
    endfunction

    // +-round(mag * 2^20 / d), capped at 2^32 in magnitude
    function automatic longint slope_div(longint mag, longint d, bit neg);
        bit [63:0] q;
        if (d <= 0)
            return 0;
        q = ((64'(mag) << 20) + (64'(d) >> 1)) / 64'(d);
        if (q > (64'd1 << 32))
            q = 64'd1 << 32;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // +-round(d * mag / 2^40)
    function automatic longint width_scale(longint d, longint mag, bit neg);
        bit [63:0] q;
        q = (64'(d) * 64'(mag) + (64'd1 << 39)) >> 40;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return SAT_MAX;
        if (v < -64'sd2147483648)
            return SAT_MIN;
        return v[31:0];
    endfunction

    // Expected basis result for one point under the current kind.
    function automatic res_t basis_eval(longint x, longint n, longint l, longint r,
                                        bit root, logic [1:0] kind);
        longint v1, g1, v2, g2, t, u;
        bit     cubic;
        res_t   res;
        v1 = 0; g1 = 0; v2 = 0; g2 = 0;
        cubic = (kind == KIND_CUBIC);
        if (root) begin
            if (x >= l && x <= r)
                v1 = ONE20;
        end
        else if (!cubic) begin
            // hat function
            if (x < n && x >= l)
                v1 = round20(coord30(x - l, n - l));
            else if (x >= n && x <= r)
                v1 = (r == n) ? ONE20 : round20(coord30(r - x, r - n));
            if (x < n && x > l)
                g1 = slope_div(ONE30, n - l, 1'b0);
            else if (x > n && x < r)
                g1 = slope_div(ONE30, r - n, 1'b1);
        end
        else begin
            // Hermite value shape
            if (x < n && x >= l) begin
                t  = coord30(x - l, n - l);
                v1 = round20(prod30(prod30(t, t), 3 * ONE30 - 2 * t));
            end
            else if (x >= n && x < r) begin
                t  = coord30(x - n, r - n);
                u  = ONE30 - t;
                v1 = round20(prod30(prod30(u, u), ONE30 + 2 * t));
            end
            else if (x == n && x == r)
                v1 = ONE20;
            if (x < n && x > l) begin
                t  = coord30(x - l, n - l);
                g1 = slope_div(6 * prod30(t, ONE30 - t), n - l, 1'b0);
            end
            else if (x > n && x < r) begin
                t  = coord30(x - n, r - n);
                g1 = slope_div(6 * prod30(t, ONE30 - t), r - n, 1'b1);
            end
            // Hermite slope shape, scaled by the half-interval width
            if (x <= n && x > l) begin
                t  = coord30(x - l, n - l);
                v2 = width_scale(n - l, prod30(prod30(t, t), ONE30 - t), 1'b1);
            end
            else if (x >= n && x < r) begin
                t  = coord30(x - n, r - n);
                u  = ONE30 - t;
                v2 = width_scale(r - n, prod30(prod30(u, u), t), 1'b0);
            end
            if (x < n && x > l) begin
                t  = coord30(x - l, n - l);
                g2 = round20(3 * prod30(t, t) - 2 * t);
            end
            else if (x > n && x < r) begin
                t  = coord30(x - n, r - n);
                g2 = round20(3 * prod30(t, t) - 4 * t + ONE30);
            end
            else if (x == n)
                g2 = ONE20;   // unit slope at the node, whatever the support
        end
        res.value_one = clip32(v1);
        res.slope_one = clip32(g1);
        res.value_two = clip32(v2);
        res.slope_two = clip32(g2);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Offer one point; it is held until accepted, and valid stays high into
    // the next item unless the sender decides to idle first.
    task automatic send_point(longint x, longint n, longint l, longint r, bit root);
        while ($urandom_range(99) < send_idle_pct) begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        eval_point  <= x[31:0];
        node_point  <= n[31:0];
        left_point  <= l[31:0];
        right_point <= r[31:0];
        is_root     <= root;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        basis_q.push_back(basis_eval(longint'(signed'(x[31:0])), longint'(signed'(n[31:0])),
                                     longint'(signed'(l[31:0])), longint'(signed'(r[31:0])),
                                     root, kind_shadow));
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding result, plus pipeline slack.
    task automatic drain;
        point_valid <= 1'b0;
        @(posedge clk);
        while (basis_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    // Only called with the pipeline empty.
    task automatic write_kind(logic [1:0] kind);
        kind_write_en   <= 1'b1;
        kind_write_data <= kind;
        @(posedge clk);
        kind_write_en   <= 1'b0;
        kind_shadow      = kind;
        @(posedge clk);
    endtask

    function automatic longint pick(longint lo, longint hi);
        bit [63:0] span;
        span = 64'(hi - lo) + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic longint fit32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // One random point: mostly well-formed supports of assorted sizes with
    // x on, near or between the knots, some degenerate supports, some pure noise.
    task automatic send_random_point;
        longint x, n, l, r, span_l, span_r;
        int     shape, width_log;
        bit     root;
        shape = $urandom_range(99);
        root  = ($urandom_range(9) == 0);
        if (shape < 8) begin
            x = signed'($urandom); n = signed'($urandom);
            l = signed'($urandom); r = signed'($urandom);
        end
        else begin
            width_log = $urandom_range(31);
            span_l = pick(1, 64'sd1 << width_log);
            width_log = $urandom_range(31);
            span_r = pick(1, 64'sd1 << width_log);
            if (shape < 14) span_l = 0;            // node on the left end
            else if (shape < 20) span_r = 0;       // node on the right end
            else if (shape < 24) span_l = -span_l; // reversed left half
            l = pick(-64'sd2147483648, 64'sd2147483647 - span_l - span_r);
            l = fit32(l);
            n = fit32(l + span_l);
            r = fit32(n + span_r);
            case ($urandom_range(7))
                0: x = l;
                1: x = n;
                2: x = r;
                3: x = fit32(l - pick(1, 8));
                4: x = fit32(r + pick(1, 8));
                default: x = fit32(pick(l < r ? l : r, l < r ? r : l));
            endcase
        end
        send_point(x, n, l, r, root);
    endtask

    // ---------------------------------------------------------------
    // Response side
    // ---------------------------------------------------------------
    always @(posedge clk)
        result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    // Compare each accepted result against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (basis_q.size() == 0) begin
                $error("result with no prediction pending");
                error_count++;
            end
            else begin
                res_t exp_res;
                exp_res = basis_q.pop_front();
                if (value_one !== exp_res.value_one) begin
                    $error("value_one expected %0d actual %0d", exp_res.value_one, value_one);
                    error_count++;
                end
                if (slope_one !== exp_res.slope_one) begin
                    $error("slope_one expected %0d actual %0d", exp_res.slope_one, slope_one);
                    error_count++;
                end
                if (value_two !== exp_res.value_two) begin
                    $error("value_two expected %0d actual %0d", exp_res.value_two, value_two);
                    error_count++;
                end
                if (slope_two !== exp_res.slope_two) begin
                    $error("slope_two expected %0d actual %0d", exp_res.slope_two, slope_two);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d predictions pending",
                     cycle_count, basis_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Knot points, extremes and degenerate supports under one kind.
    task automatic test_directed_points;
        longint lo, hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        send_point(0, 0, -ONE30, ONE30, 1'b0);              // node itself
        send_point(-ONE30, 0, -ONE30, ONE30, 1'b0);         // left end
        send_point(ONE30, 0, -ONE30, ONE30, 1'b0);          // right end
        send_point(-ONE30 / 2, 0, -ONE30, ONE30, 1'b0);     // mid left half
        send_point(ONE30 / 3, 0, -ONE30, ONE30, 1'b0);      // inside right half
        send_point(lo, 0, lo, hi, 1'b0);                    // full range support
        send_point(hi, 0, lo, hi, 1'b0);
        send_point(lo + 1, 0, lo, hi, 1'b0);
        send_point(hi - 1, hi - 1, lo, hi - 1, 1'b0);       // x == N == R
        send_point(hi, hi, hi, hi, 1'b0);                   // empty support
        send_point(5, 10, 20, 0, 1'b0);                     // reversed support
        send_point(10, 10, 20, 0, 1'b0);                    // reversed, x on node
        send_point(1, 2, 0, 4, 1'b0);                       // tiny halves, saturation
        send_point(3, 2, 0, 4, 1'b0);
        send_point(0, 0, 0, ONE30, 1'b0);                   // node on left end
        send_point(lo, lo, lo, lo + 1, 1'b0);
        send_point(0, lo, lo, hi, 1'b1);                    // root inside
        send_point(lo, lo, lo, hi, 1'b1);                   // root on ends
        send_point(hi, 0, lo, hi, 1'b1);
        send_point(-1, 0, 0, 5, 1'b1);                      // root outside
        send_point(6, 0, 0, 5, 1'b1);
    endtask

    task automatic test_directed;
        test_directed_points();
        drain();
        write_kind(KIND_CUBIC);
        test_directed_points();
        drain();
        write_kind(KIND_QUADRATIC);
        test_directed_points();
        drain();
        write_kind(KIND_SPARE);
        test_directed_points();
        drain();
    endtask

    // Random points in phases, rotating the kind between phases.
    task automatic test_random(int count, int send_pct, int recv_pct);
        logic [1:0] kinds[4];
        kinds = '{KIND_CUBIC, KIND_LINEAR, KIND_CUBIC, KIND_QUADRATIC};
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int phase = 0; phase < 4; phase++) begin
            write_kind(kinds[phase]);
            for (int i = 0; i < count / 4; i++)
                send_random_point();
            drain();   // sender pauses until every result is back
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and push back.
    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_kind(KIND_CUBIC);
        fork
            begin
                hold_off <= 1'b1;
                repeat (250) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int i = 0; i < 150; i++)
            send_random_point();
        drain();
        write_kind(KIND_LINEAR);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600, 22, 74);
        test_random(600, 74, 22);
        test_random(400, 0, 0);
        test_backpressure();
        $display("covered %0d points, %0d results: all basis kinds, knots, extremes,",
                 items_sent, results_seen);
        $display("degenerate and root supports, random idling and a full-pipeline hold-off");
        if (error_count == 0 && basis_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
